// File: rtl/core/mlpc_pkg.sv
// Package for the marker landing PI phase controller.
// Holds fixed-point constants, configuration, payload and queue entry types.
// No dependencies; every other file of the block imports it.
`timescale 1ns / 1ps

package mlpc_pkg;

  // Fractional bits of positions, errors, integrals and velocities.
  localparam int FRAC_BITS = 12;

  // Fixed-point constants, rounded to the nearest Q.F value.
  localparam int ONE_Q     = 1 << FRAC_BITS;
  localparam int HALF_Q    = 1 << (FRAC_BITS - 1);
  localparam int QUARTER_Q = 1 << (FRAC_BITS - 2);
  localparam int TEN_Q     = 10 << FRAC_BITS;
  localparam int C0P3_Q    = ((3 << FRAC_BITS) + 5) / 10;
  localparam int C0P1_Q    = ((1 << FRAC_BITS) + 5) / 10;
  localparam int C0P2_Q    = ((2 << FRAC_BITS) + 5) / 10;
  localparam int C1P1_Q    = ((11 << FRAC_BITS) + 5) / 10;

  // Folded body X and Y and their errors span +-1.0, and the negated
  // 16-bit camera input needs 17 bits.
  localparam int PW = (FRAC_BITS + 2 > 17) ? FRAC_BITS + 2 : 17;
  // Body Z is a negated 16-bit input; the Z error adds a 16-bit target.
  localparam int BZW = 17;
  localparam int EZW = 18;
  // Integrals span +-10.0.
  localparam int IW = $clog2(TEN_Q + 1) + 1;
  // Gains enter the multipliers as 17-bit signed values.
  localparam int GW = 17;
  // Sum of the two X or Y products.
  localparam int ACCW = GW + ((PW > IW) ? PW : IW) + 1;

  // Configuration register indexes.
  localparam logic [2:0] CFG_GAIN_P_XY       = 3'd0;
  localparam logic [2:0] CFG_GAIN_P_Z        = 3'd1;
  localparam logic [2:0] CFG_GAIN_I_XY       = 3'd2;
  localparam logic [2:0] CFG_HEIGHT_APPROACH = 3'd3;
  localparam logic [2:0] CFG_HEIGHT_FINAL    = 3'd4;
  localparam logic [2:0] CFG_WINDOW_LENGTH   = 3'd5;
  localparam logic [2:0] CFG_WINDOW_REQUIRED = 3'd6;

  typedef struct packed {
    logic        [15:0] gain_p_xy;
    logic        [15:0] gain_p_z;
    logic        [15:0] gain_i_xy;
    logic signed [15:0] height_approach;
    logic signed [15:0] height_final;
    logic        [7:0]  window_length;
    logic        [7:0]  window_required;
  } cfg_t;

  typedef struct packed {
    logic signed [15:0] cam_pos_x;
    logic signed [15:0] cam_pos_y;
    logic signed [15:0] cam_pos_z;
    logic               marker_seen;
    logic        [3:0]  new_detections;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] vel_x;
    logic signed [15:0] vel_y;
    logic signed [15:0] vel_z;
    logic        [1:0]  phase_out;
  } out_item_t;

  // One classified tick, waiting for its velocity products.
  typedef struct packed {
    logic signed [PW-1:0]  err_x;
    logic signed [PW-1:0]  err_y;
    logic signed [EZW-1:0] err_z;
    logic signed [IW-1:0]  int_x;
    logic signed [IW-1:0]  int_y;
    logic                  seen;
    logic        [1:0]     phase;
  } work_t;

endpackage

// File: rtl/core/mlpc_front.sv
// Front end: takes each tick, forms the errors and updates the integrals,
// window counters and landing phase. Depends on mlpc_pkg.
`timescale 1ns / 1ps

module mlpc_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  mlpc_pkg::cfg_t   cfg_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  mlpc_pkg::in_item_t in_item_i,
  input  logic             q_ready_i,
  output logic             q_push_o,
  output mlpc_pkg::work_t  q_work_o
);
  import mlpc_pkg::*;

  typedef enum logic [1:0] {
    PH_ACQUIRE,
    PH_ALIGN,
    PH_DESCEND,
    PH_FINAL
  } phase_e;

  phase_e               phase_q, phase_d;
  logic signed [IW-1:0] int_x_q, int_x_d;
  logic signed [IW-1:0] int_y_q, int_y_d;
  logic        [7:0]    win_total_q, win_total_d;
  logic        [7:0]    win_seen_q, win_seen_d;

  logic signed [16:0]    neg_x, neg_y;
  logic signed [PW-1:0]  body_x, body_y, err_x, err_y;
  logic signed [BZW-1:0] body_z;
  logic signed [15:0]    target;
  logic signed [EZW-1:0] err_z;
  logic signed [IW:0]    sum_x, sum_y;
  logic        [8:0]     tot_sum;
  logic        [7:0]     tot_sat, seen_cnt;
  logic                  seen, win_hit;
  phase_e                phase_a, phase_b;

  // Values beyond +-1.0 fold back to +-0.5.
  function automatic logic signed [PW-1:0] fold(input logic signed [16:0] v);
    logic signed [PW-1:0] r;
    if (v > ONE_Q) begin
      r = PW'(HALF_Q);
    end else if (v < -ONE_Q) begin
      r = -PW'(HALF_Q);
    end else begin
      r = PW'(v);
    end
    return r;
  endfunction

  function automatic logic signed [IW-1:0] clamp_i(input logic signed [IW:0] v);
    logic signed [IW-1:0] r;
    if (v > TEN_Q) begin
      r = IW'(TEN_Q);
    end else if (v < -TEN_Q) begin
      r = -IW'(TEN_Q);
    end else begin
      r = v[IW-1:0];
    end
    return r;
  endfunction

  // The front takes a transfer whenever the queue has room.
  assign in_ready_o = q_ready_i;
  assign q_push_o   = in_valid_i && q_ready_i;
  assign seen       = in_item_i.marker_seen;

  // Body frame: swapped and negated camera position, X and Y folded.
  always_comb begin
    neg_x  = -17'(in_item_i.cam_pos_y);
    neg_y  = -17'(in_item_i.cam_pos_x);
    body_x = fold(neg_x);
    body_y = fold(neg_y);
    body_z = -BZW'(in_item_i.cam_pos_z);
    err_x  = -body_x;
    err_y  = -body_y;
    target = (phase_q >= PH_DESCEND) ? cfg_i.height_final : cfg_i.height_approach;
    err_z  = EZW'(target) - EZW'(body_z);
  end

  // Integrals with clamp at +-10.
  always_comb begin
    sum_x   = (IW+1)'(int_x_q) + (IW+1)'(err_x);
    sum_y   = (IW+1)'(int_y_q) + (IW+1)'(err_y);
    int_x_d = clamp_i(sum_x);
    int_y_d = clamp_i(sum_y);
  end

  // Acquisition window counters, saturating at 255.
  always_comb begin
    tot_sum  = {1'b0, win_total_q} + 9'(in_item_i.new_detections);
    tot_sat  = tot_sum[8] ? 8'hFF : tot_sum[7:0];
    seen_cnt = (seen && (win_seen_q != 8'hFF)) ? win_seen_q + 8'd1 : win_seen_q;
    win_hit  = tot_sat >= cfg_i.window_length;
    win_total_d = win_hit ? 8'd0 : tot_sat;
    win_seen_d  = win_hit ? 8'd0 : seen_cnt;
  end

  // Phase sequencing; the descend and final checks may both pass in one tick.
  always_comb begin
    phase_a = phase_q;
    if (win_hit && (phase_q == PH_ACQUIRE) && (seen_cnt >= cfg_i.window_required)) begin
      phase_a = PH_ALIGN;
    end
    phase_b = phase_a;
    if ((phase_a == PH_ALIGN) && (err_x > -C0P3_Q) && (err_x < C0P3_Q) &&
        (err_y > -C0P3_Q) && (err_y < C0P3_Q) && (body_z < -QUARTER_Q) &&
        (body_z > -C1P1_Q) && seen) begin
      phase_b = PH_DESCEND;
    end
    phase_d = phase_b;
    if ((phase_b == PH_DESCEND) && (err_x > -C0P1_Q) && (err_x < C0P1_Q) &&
        (err_y > -C0P1_Q) && (err_y < C0P1_Q) && (body_z > -C0P2_Q) && seen) begin
      phase_d = PH_FINAL;
    end
  end

  // Queue entry for the back end.
  always_comb begin
    q_work_o.err_x = err_x;
    q_work_o.err_y = err_y;
    q_work_o.err_z = err_z;
    q_work_o.int_x = int_x_d;
    q_work_o.int_y = int_y_d;
    q_work_o.seen  = seen;
    q_work_o.phase = phase_d;
  end

  // Controller state advances on every accepted transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_ACQUIRE;
      int_x_q     <= '0;
      int_y_q     <= '0;
      win_total_q <= '0;
      win_seen_q  <= '0;
    end else if (q_push_o) begin
      phase_q     <= phase_d;
      int_x_q     <= int_x_d;
      int_y_q     <= int_y_d;
      win_total_q <= win_total_d;
      win_seen_q  <= win_seen_d;
    end
  end

endmodule

// File: rtl/core/mlpc_queue.sv
// Two-entry queue between the front and back ends.
// Depends on mlpc_pkg for the entry type.
`timescale 1ns / 1ps

module mlpc_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  mlpc_pkg::work_t push_work_i,
  output logic            push_ready_o,
  input  logic            pop_i,
  output logic            pop_valid_o,
  output mlpc_pkg::work_t pop_work_o
);
  import mlpc_pkg::*;

  work_t      entry_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;

  assign push_ready_o = count_q != 2'd2;
  assign pop_valid_o  = count_q != 2'd0;
  assign pop_work_o   = entry_q[rd_ptr_q];

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_work_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 2'd1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

endmodule

// File: rtl/core/mlpc_back.sv
// Back end: PI and P velocity products, rounding, saturation and the
// output register. Depends on mlpc_pkg.
`timescale 1ns / 1ps

module mlpc_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mlpc_pkg::cfg_t     cfg_i,
  input  logic               q_valid_i,
  input  mlpc_pkg::work_t    q_work_i,
  output logic               q_pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output mlpc_pkg::out_item_t out_item_o
);
  import mlpc_pkg::*;

  localparam int PXW = GW + PW;
  localparam int PIW = GW + IW;
  localparam int PZW = GW + EZW;

  logic                  out_valid_q;
  out_item_t             out_item_q, out_item_d;
  logic signed [GW-1:0]  gp_xy, gi_xy, gp_z;
  logic signed [PXW-1:0] prod_px, prod_py;
  logic signed [PIW-1:0] prod_ix, prod_iy;
  logic signed [PZW-1:0] prod_z;
  logic signed [ACCW-1:0] acc_x, acc_y, acc_z;

  // Round half up from Q(F+16) to Q.F, then saturate to 16 bits.
  function automatic logic [15:0] to_vel(input logic signed [ACCW-1:0] v);
    logic signed [ACCW:0]    r;
    logic signed [ACCW-16:0] q;
    logic        [15:0]      res;
    r = (ACCW+1)'(v) + (ACCW+1)'(32768);
    q = r[ACCW:16];
    if (q > 32767) begin
      res = 16'h7FFF;
    end else if (q < -32768) begin
      res = 16'h8000;
    end else begin
      res = q[15:0];
    end
    return res;
  endfunction

  assign q_pop_o     = q_valid_i && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // Velocity products.
  always_comb begin
    gp_xy   = $signed({1'b0, cfg_i.gain_p_xy});
    gi_xy   = $signed({1'b0, cfg_i.gain_i_xy});
    gp_z    = $signed({1'b0, cfg_i.gain_p_z});
    prod_px = PXW'(gp_xy) * PXW'(q_work_i.err_x);
    prod_py = PXW'(gp_xy) * PXW'(q_work_i.err_y);
    prod_ix = PIW'(gi_xy) * PIW'(q_work_i.int_x);
    prod_iy = PIW'(gi_xy) * PIW'(q_work_i.int_y);
    prod_z  = PZW'(gp_z) * PZW'(q_work_i.err_z);
    acc_x   = ACCW'(prod_px) + ACCW'(prod_ix);
    acc_y   = ACCW'(prod_py) + ACCW'(prod_iy);
    acc_z   = ACCW'(prod_z);
  end

  // Result fields; all zero when the marker is not seen.
  always_comb begin
    if (q_work_i.seen) begin
      out_item_d.vel_x     = to_vel(acc_x);
      out_item_d.vel_y     = to_vel(acc_y);
      out_item_d.vel_z     = to_vel(acc_z);
      out_item_d.phase_out = q_work_i.phase;
    end else begin
      out_item_d = '0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      out_item_q <= out_item_d;
    end
  end

  // Output valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (q_pop_o) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

endmodule

// File: rtl/core/marker_landing_pi_phase_control_unit.sv
// Top level of the marker landing PI phase controller: configuration
// registers, front end, queue and back end. Depends on mlpc_pkg, mlpc_front,
// mlpc_queue and mlpc_back.
//
//   Channel  Direction  Handshake              Payload
//   in       input      in_valid_i/in_ready_o   in_item_i (in_item_t)
//   out      output     out_valid_o/out_ready_i out_item_o (out_item_t)
//   cfg      input      cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// One tick per cycle sustained while the output is not stalled. A transferred
// tick is written to the queue and the back pops it into the output register:
// the front updates the controller state on the transfer, the back forms the
// products from the popped entry. Reset clears the phase, integrals and window
// counters and loads the register reset values. A stalled output holds its
// result while the two-entry queue lets the front accept; it stalls when full.
`timescale 1ns / 1ps

module marker_landing_pi_phase_control_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  mlpc_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output mlpc_pkg::out_item_t out_item_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [2:0]          cfg_index_i,
  input  logic [15:0]         cfg_data_i
);
  import mlpc_pkg::*;

  cfg_t  cfg_q;
  logic  q_push, q_ready, q_pop, q_valid;
  work_t push_work, pop_work;

  assign cfg_ready_o = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain_p_xy       <= 16'd26214;
      cfg_q.gain_p_z        <= 16'd9830;
      cfg_q.gain_i_xy       <= 16'd786;
      cfg_q.height_approach <= -16'sd2253;
      cfg_q.height_final    <= -16'sd410;
      cfg_q.window_length   <= 8'd30;
      cfg_q.window_required <= 8'd25;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_GAIN_P_XY:       cfg_q.gain_p_xy       <= cfg_data_i;
        CFG_GAIN_P_Z:        cfg_q.gain_p_z        <= cfg_data_i;
        CFG_GAIN_I_XY:       cfg_q.gain_i_xy       <= cfg_data_i;
        CFG_HEIGHT_APPROACH: cfg_q.height_approach <= cfg_data_i;
        CFG_HEIGHT_FINAL:    cfg_q.height_final    <= cfg_data_i;
        CFG_WINDOW_LENGTH:   cfg_q.window_length   <= cfg_data_i[7:0];
        CFG_WINDOW_REQUIRED: cfg_q.window_required <= cfg_data_i[7:0];
        default: begin
        end
      endcase
    end
  end

  mlpc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .q_ready_i  (q_ready),
    .q_push_o   (q_push),
    .q_work_o   (push_work)
  );

  mlpc_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (q_push),
    .push_work_i  (push_work),
    .push_ready_o (q_ready),
    .pop_i        (q_pop),
    .pop_valid_o  (q_valid),
    .pop_work_o   (pop_work)
  );

  mlpc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_valid_i   (q_valid),
    .q_work_i    (pop_work),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

// File: rtl/core/mlpc_checker.sv
// Port-level checks for the marker landing PI phase controller and the bind
// that attaches them to the top level. Depends on mlpc_pkg.
`timescale 1ns / 1ps

module mlpc_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input mlpc_pkg::out_item_t out_item_o,
  input logic                cfg_ready_o
);
  import mlpc_pkg::*;

  // A stalled result holds its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result changed");

  // No result is shown while reset is asserted.
  assert property (@(posedge clk_i) !rst_ni |-> !out_valid_o)
    else $error("result valid during reset");

  // The input side only stalls when the queue is full behind a held result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with empty output");

  // A fresh result follows a matching input transfer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o, 2))
    else $error("result without a matching input transfer");

  // The configuration port always takes a write.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o)
    else $error("configuration port not ready");

endmodule

bind marker_landing_pi_phase_control_unit mlpc_checker u_checker (.*);

// File: bench/mlpc_landing_checker.sv
// Checker for the marker landing PI phase controller: watches the tick, result
// and register channels, predicts every result and compares it on arrival.
// Depends on mlpc_pkg for the payload types and register indexes.
`timescale 1ns / 1ps

module mlpc_landing_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  mlpc_pkg::in_item_t  in_item_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  mlpc_pkg::out_item_t out_item_i,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_i,
  input  logic [2:0]          cfg_index_i,
  input  logic [15:0]         cfg_data_i,
  output int                  pending_o,
  output int                  fail_count_o
);
  import mlpc_pkg::*;

  typedef enum logic [1:0] {
    PH_SEARCH,
    PH_ACQUIRED,
    PH_DESCENT,
    PH_LANDED
  } landing_phase_e;

  // Register values after reset.
  localparam logic [15:0] RST_GAIN_P_XY       = 16'd26214;
  localparam logic [15:0] RST_GAIN_P_Z        = 16'd9830;
  localparam logic [15:0] RST_GAIN_I_XY       = 16'd786;
  localparam logic [15:0] RST_HEIGHT_APPROACH = -16'sd2253;
  localparam logic [15:0] RST_HEIGHT_FINAL    = -16'sd410;
  localparam logic [7:0]  RST_WINDOW_LENGTH   = 8'd30;
  localparam logic [7:0]  RST_WINDOW_REQUIRED = 8'd25;

  localparam int COUNT_MAX    = 255;
  localparam int REPORT_LIMIT = 100;

  // Shadow copy of the registers and of the controller state.
  cfg_t           regs;
  landing_phase_e phase_q;
  int             integ_x;
  int             integ_y;
  int             win_total;
  int             win_seen;
  out_item_t      vel_expect_q[$];
  int             mismatches;

  // Body X and Y beyond one metre fold back to half a metre.
  function automatic int fold_body(int v);
    if (v > ONE_Q) return HALF_Q;
    if (v < -ONE_Q) return -HALF_Q;
    return v;
  endfunction

  function automatic int clamp_integral(int v);
    if (v > TEN_Q) return TEN_Q;
    if (v < -TEN_Q) return -TEN_Q;
    return v;
  endfunction

  // Round half up from Q(F+16) to Q.F, then saturate to 16 bits.
  function automatic logic signed [15:0] round_velocity(longint acc);
    longint q;
    q = (acc + 32768) >>> 16;
    if (q > 32767) q = 32767;
    else if (q < -32768) q = -32768;
    return q[15:0];
  endfunction

  function automatic bit in_band(int v, int lim);
    return (v > -lim) && (v < lim);
  endfunction

  // One control tick: updates the shadow state and returns the expected result.
  function automatic out_item_t advance_controller(in_item_t it);
    int        bx;
    int        by;
    int        bz;
    int        ex;
    int        ey;
    int        ez;
    int        target;
    bit        seen;
    out_item_t res;
    bx     = fold_body(-int'(it.cam_pos_y));
    by     = fold_body(-int'(it.cam_pos_x));
    bz     = -int'(it.cam_pos_z);
    seen   = it.marker_seen;
    target = (phase_q >= PH_DESCENT) ? int'(regs.height_final) : int'(regs.height_approach);
    ex     = -bx;
    ey     = -by;
    ez     = target - bz;

    integ_x = clamp_integral(integ_x + ex);
    integ_y = clamp_integral(integ_y + ey);

    // Acquisition window bookkeeping; both counters stick at their maximum.
    win_total = win_total + int'(it.new_detections);
    if (win_total > COUNT_MAX) win_total = COUNT_MAX;
    if (seen && win_seen < COUNT_MAX) win_seen++;
    if (win_total >= int'(regs.window_length)) begin
      if (phase_q == PH_SEARCH && win_seen >= int'(regs.window_required)) begin
        phase_q = PH_ACQUIRED;
      end
      win_total = 0;
      win_seen  = 0;
    end

    // Descent starts inside the 0.3 m box between 0.25 m and 1.1 m down.
    if (phase_q == PH_ACQUIRED && in_band(ex, C0P3_Q) && in_band(ey, C0P3_Q) &&
        bz < -QUARTER_Q && bz > -C1P1_Q && seen) begin
      phase_q = PH_DESCENT;
    end
    if (phase_q == PH_DESCENT && in_band(ex, C0P1_Q) && in_band(ey, C0P1_Q) &&
        bz > -C0P2_Q && seen) begin
      phase_q = PH_LANDED;
    end

    res = '0;
    if (seen) begin
      res.vel_x     = round_velocity(longint'(regs.gain_p_xy) * ex +
                                     longint'(regs.gain_i_xy) * integ_x);
      res.vel_y     = round_velocity(longint'(regs.gain_p_xy) * ey +
                                     longint'(regs.gain_i_xy) * integ_y);
      res.vel_z     = round_velocity(longint'(regs.gain_p_z) * ez);
      res.phase_out = phase_q;
    end
    return res;
  endfunction

  // Keep the log short once a design is clearly broken.
  task automatic report_mismatch(string msg);
    mismatches++;
    if (mismatches <= REPORT_LIMIT) $display("%0t ns: mismatch: %s", $time, msg);
  endtask

  // Register writes, result checks and tick predictions, in that order, so that
  // a result can never be matched against a tick of the same edge.
  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      regs.gain_p_xy       = RST_GAIN_P_XY;
      regs.gain_p_z        = RST_GAIN_P_Z;
      regs.gain_i_xy       = RST_GAIN_I_XY;
      regs.height_approach = RST_HEIGHT_APPROACH;
      regs.height_final    = RST_HEIGHT_FINAL;
      regs.window_length   = RST_WINDOW_LENGTH;
      regs.window_required = RST_WINDOW_REQUIRED;
      phase_q   = PH_SEARCH;
      integ_x   = 0;
      integ_y   = 0;
      win_total = 0;
      win_seen  = 0;
      vel_expect_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_GAIN_P_XY:       regs.gain_p_xy       = cfg_data_i;
          CFG_GAIN_P_Z:        regs.gain_p_z        = cfg_data_i;
          CFG_GAIN_I_XY:       regs.gain_i_xy       = cfg_data_i;
          CFG_HEIGHT_APPROACH: regs.height_approach = cfg_data_i;
          CFG_HEIGHT_FINAL:    regs.height_final    = cfg_data_i;
          CFG_WINDOW_LENGTH:   regs.window_length   = cfg_data_i[7:0];
          CFG_WINDOW_REQUIRED: regs.window_required = cfg_data_i[7:0];
          default: ;
        endcase
      end

      if (out_valid_i && out_ready_i) begin
        if (vel_expect_q.size() == 0) begin
          report_mismatch("result transfer with no tick waiting");
        end else begin
          want = vel_expect_q.pop_front();
          if (out_item_i.vel_x !== want.vel_x || out_item_i.vel_y !== want.vel_y ||
              out_item_i.vel_z !== want.vel_z || out_item_i.phase_out !== want.phase_out) begin
            report_mismatch($sformatf(
              "vel_x %0d/%0d vel_y %0d/%0d vel_z %0d/%0d phase %0d/%0d (got/expected)",
              out_item_i.vel_x, want.vel_x, out_item_i.vel_y, want.vel_y,
              out_item_i.vel_z, want.vel_z, out_item_i.phase_out, want.phase_out));
          end
        end
      end

      if (in_valid_i && in_ready_i) begin
        vel_expect_q.push_back(advance_controller(in_item_i));
      end
    end
    pending_o    <= vel_expect_q.size();
    fail_count_o <= mismatches;
  end

endmodule

// File: bench/tb_marker_landing_pi_phase_control_unit.sv
// Testbench top for the marker landing PI phase controller: clock, reset,
// tick stimulus, register settings and the verdict.
// Depends on mlpc_pkg, the block's RTL and mlpc_landing_checker.
`timescale 1ns / 1ps

module tb_marker_landing_pi_phase_control_unit;
  import mlpc_pkg::*;

  localparam int RESET_CYCLES    = 12;
  localparam int HOLD_OFF_CYCLES = 40;
  localparam int DRAIN_CYCLES    = 8;
  localparam int CYCLE_LIMIT     = 200000;
  localparam int LANDING_TICKS   = 300;
  localparam int QUIET_FROM      = 200;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  in_item_t    in_item_i;
  logic        out_valid_o;
  logic        out_ready_i;
  out_item_t   out_item_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i;
  logic [15:0] cfg_data_i;
  int          pending;
  int          fail_count;

  // Idling controls shared by the sender and the receiver.
  int idle_pct;
  bit quiet;
  bit hold_off_req;

  marker_landing_pi_phase_control_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  mlpc_landing_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .in_item_i    (in_item_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_item_i   (out_item_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .pending_o    (pending),
    .fail_count_o (fail_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // The run ends here if the block hangs.
  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("FAIL marker_landing_pi_phase_control_unit");
    $finish;
  end

  // Result receiver: random short stalls, plus one long hold-off on request so
  // that the block fills up and stalls its tick input.
  initial begin
    bit held;
    held        = 1'b0;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_off_req && !held) begin
        held = 1'b1;
        out_ready_i <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end else if (!quiet && $urandom_range(99) < idle_pct) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(3, 1)) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  function automatic in_item_t make_tick(int x, int y, int z, bit seen, int nd);
    in_item_t it;
    it.cam_pos_x      = 16'(x);
    it.cam_pos_y      = 16'(y);
    it.cam_pos_z      = 16'(z);
    it.marker_seen    = seen;
    it.new_detections = 4'(nd);
    return it;
  endfunction

  // Uniform value in -lim..lim.
  function automatic int near_zero(int lim);
    return int'($urandom_range(2 * lim)) - lim;
  endfunction

  // Arbitrary tick: either any 16-bit position or one around the fold limit.
  function automatic in_item_t noise_tick();
    if ($urandom_range(1)) begin
      return make_tick($urandom, $urandom, $urandom, 1'($urandom_range(1)),
                       $urandom_range(15));
    end
    return make_tick(near_zero(5000), near_zero(5000), near_zero(5000),
                     1'($urandom_range(1)), $urandom_range(15));
  endfunction

  // Sends one tick, with an occasional gap before it; valid stays high after
  // the transfer so that back-to-back ticks need no second assignment.
  task automatic send_tick(input in_item_t it);
    if (!quiet && $urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic send_noise(int count);
    repeat (count) send_tick(noise_tick());
  endtask

  // Stops offering ticks and waits until every result has come back.
  task automatic drain_ticks();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Writes all seven registers; only called while the block is idle.
  task automatic program_regs(input cfg_t c);
    for (int idx = CFG_GAIN_P_XY; idx <= CFG_WINDOW_REQUIRED; idx++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= 3'(idx);
      case (3'(idx))
        CFG_GAIN_P_XY:       cfg_data_i <= c.gain_p_xy;
        CFG_GAIN_P_Z:        cfg_data_i <= c.gain_p_z;
        CFG_GAIN_I_XY:       cfg_data_i <= c.gain_i_xy;
        CFG_HEIGHT_APPROACH: cfg_data_i <= c.height_approach;
        CFG_HEIGHT_FINAL:    cfg_data_i <= c.height_final;
        CFG_WINDOW_LENGTH:   cfg_data_i <= {8'd0, c.window_length};
        default:             cfg_data_i <= {8'd0, c.window_required};
      endcase
      do @(posedge clk_i); while (!cfg_ready_o);
    end
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    cfg_t setting;
    int   sent;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    in_item_i    = '0;
    cfg_valid_i  = 1'b0;
    cfg_index_i  = CFG_GAIN_P_XY;
    cfg_data_i   = '0;
    idle_pct     = 20;
    quiet        = 1'b0;
    hold_off_req = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed ticks at the reset settings: field extremes, the fold limit,
    // an unseen marker and an integral driven into its clamp and back.
    send_tick(make_tick(0, 0, 0, 1'b0, 0));
    send_tick(make_tick(32767, 32767, 32767, 1'b1, 15));
    send_tick(make_tick(-32768, -32768, -32768, 1'b1, 15));
    send_tick(make_tick(-32767, -32767, -32767, 1'b0, 15));
    send_tick(make_tick(ONE_Q, -ONE_Q, 0, 1'b1, 1));
    send_tick(make_tick(ONE_Q + 1, -ONE_Q - 1, 0, 1'b1, 1));
    send_tick(make_tick(-ONE_Q - 1, ONE_Q + 1, 1, 1'b1, 0));
    send_tick(make_tick(1000, -2000, 3000, 1'b0, 7));
    repeat (12) send_tick(make_tick(ONE_Q, ONE_Q, 2000, 1'b1, 0));
    repeat (3) send_tick(make_tick(-ONE_Q, -ONE_Q, -2000, 1'b1, 0));
    drain_ticks();

    // Window too demanding to leave the search phase; counters saturate.
    setting = '{gain_p_xy: 16'd0, gain_p_z: 16'hFFFF, gain_i_xy: 16'hFFFF,
                height_approach: 16'h8000, height_final: 16'h7FFF,
                window_length: 8'd255, window_required: 8'd255};
    idle_pct = 30;
    program_regs(setting);
    send_noise(120);
    drain_ticks();

    // Zero-length window closes on every tick; no idling in this stretch.
    setting = '{gain_p_xy: 16'hFFFF, gain_p_z: 16'd0, gain_i_xy: 16'd0,
                height_approach: 16'h7FFF, height_final: 16'h8000,
                window_length: 8'd0, window_required: 8'd255};
    idle_pct = 0;
    program_regs(setting);
    send_noise(120);
    drain_ticks();

    // One-tick window enters phase 1 at once; the receiver holds off midway.
    setting = '{gain_p_xy: 16'($urandom), gain_p_z: 16'($urandom), gain_i_xy: 16'($urandom),
                height_approach: 16'($urandom), height_final: 16'($urandom),
                window_length: 8'd1, window_required: 8'd1};
    idle_pct = 30;
    program_regs(setting);
    send_noise(60);
    hold_off_req = 1'b1;
    send_noise(90);
    drain_ticks();

    // Landing runs: approach ticks inside the descent box, then descent ticks
    // inside the touchdown box, mixed with arbitrary ticks.
    setting = '{gain_p_xy: 16'($urandom_range(40000)), gain_p_z: 16'($urandom_range(40000)),
                gain_i_xy: 16'($urandom_range(4000)), height_approach: -16'sd2253,
                height_final: -16'sd410, window_length: 8'd30, window_required: 8'd25};
    idle_pct = 25;
    program_regs(setting);
    sent = 0;
    while (sent < LANDING_TICKS) begin
      if (sent >= QUIET_FROM) quiet = 1'b1;
      if ($urandom_range(99) < 70) begin
        repeat ($urandom_range(8, 3)) begin
          send_tick(make_tick(near_zero(1300), near_zero(1300), 900 + $urandom_range(3700),
                              $urandom_range(9) != 0, $urandom_range(2)));
          sent++;
        end
        repeat ($urandom_range(8, 3)) begin
          send_tick(make_tick(near_zero(450), near_zero(450),
                              int'($urandom_range(2900)) - 2000,
                              $urandom_range(9) != 0, $urandom_range(2)));
          sent++;
        end
      end else begin
        send_tick(noise_tick());
        sent++;
      end
    end
    drain_ticks();

    if (fail_count == 0) begin
      $display("PASS marker_landing_pi_phase_control_unit");
    end else begin
      $display("FAIL marker_landing_pi_phase_control_unit");
    end
    $finish;
  end

endmodule
